>>> src/pfba_pkg.sv
package pfba_pkg;

    localparam int unsigned MAX_PAGES_DEF = 4096;
    localparam int unsigned WORD_BITS     = 32;
    localparam int unsigned FRAME_SHIFT   = 12;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_NO_FREE       = 3'd1;
    localparam logic [2:0] ST_UNALIGNED     = 3'd2;
    localparam logic [2:0] ST_NOT_ALLOCATED = 3'd3;
    localparam logic [2:0] ST_OUT_OF_RANGE  = 3'd4;

    localparam logic       CMD_ALLOC = 1'b0;
    localparam logic       CMD_FREE  = 1'b1;

    localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_PAGE_COUNT   = 2'd1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_CHK,
        S_FREE_CHK
    } t_state;

endpackage

>>> src/page_frame_bitmap_allocator_top.sv
// Bitmap page frame allocator, one bit per 4 KiB frame in 32-bit words.
// Command channel: a transaction is taken at a rising edge with i_start high
// and o_busy low; i_cmd selects allocate or free, i_page_address is the frame
// to free. Each transaction gives one result on o_granted_address and
// o_status, shown for exactly one cycle with o_valid high; the receiver
// cannot stall, so nothing is held back.
// A free that fails the alignment or range test is answered from the idle
// state; any other free reads its bitmap word first. An allocate reads
// bitmap word 0 when taken and answers once the grant falls in the word in
// hand or that word is the last one below the page count; the scan reads one
// bitmap word per cycle through the single memory read port. A new command
// may start in the cycle the previous result is shown.
// Reset: the bitmap memory is swept to zero, one word per cycle, with o_busy
// high; base address and page count reset to zero. The configuration port
// writes i_cfg_wdata to register i_cfg_idx (0 base address, 1 page count,
// bits 12:0 only) at any edge outside reset with i_cfg_we high.
module page_frame_bitmap_allocator_top #(
    parameter int unsigned MAX_PAGES = pfba_pkg::MAX_PAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_cmd,
    input  logic [31:0] i_page_address,
    output logic        o_valid,
    output logic [31:0] o_granted_address,
    output logic [2:0]  o_status,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);

    localparam int unsigned MAP_WORDS = (MAX_PAGES + pfba_pkg::WORD_BITS - 1)
                                        / pfba_pkg::WORD_BITS;
    localparam int unsigned WRD_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned LIM_W     = $clog2(MAX_PAGES + 1);
    localparam int unsigned UW        = LIM_W - 4;

    pfba_pkg::t_state r_state, n_state;

    logic [31:0]      r_mem [MAP_WORDS];
    logic [31:0]      r_mem_q;
    logic [WRD_W-1:0] r_word, n_word;
    logic [4:0]       r_bit, n_bit;
    logic [31:0]      r_base;
    logic [12:0]      r_page_count;
    logic             r_valid, n_valid;
    logic [31:0]      r_grant, n_grant;
    logic [2:0]       r_status, n_status;

    logic             w_rd_en;
    logic [WRD_W-1:0] w_rd_addr;
    logic             w_wr_en;
    logic [WRD_W-1:0] w_wr_addr;
    logic [31:0]      w_wr_data;

    logic [LIM_W-1:0] w_limit;
    logic [UW-1:0]    w_words_used;
    logic             w_last_word;
    logic             w_word_lt;
    logic             w_word_eq;
    logic [31:0]      w_used;
    logic             w_found;
    logic [4:0]       w_found_bit;
    logic [31:0]      w_grant_addr;
    logic [31:0]      w_offset;
    logic             w_unaligned;
    logic             w_out_of_range;
    logic             w_clr_last;

    function automatic logic [4:0] first_zero(input logic [31:0] word);
        logic [4:0] pos;
        pos = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (!word[i]) begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

    // effective page count, saturated at the built capacity
    always_comb begin
        if (32'(r_page_count) > 32'(MAX_PAGES)) begin
            w_limit = LIM_W'(MAX_PAGES);
        end else begin
            w_limit = LIM_W'(r_page_count);
        end
    end

    assign w_words_used = UW'(w_limit >> 5) + UW'(|w_limit[4:0]);
    assign w_last_word  = (UW'(r_word) + UW'(1)) >= w_words_used;
    assign w_word_lt    = 32'(r_word) < 32'(w_limit >> 5);
    assign w_word_eq    = 32'(r_word) == 32'(w_limit >> 5);

    // pages at or beyond the count look taken
    always_comb begin
        if (w_word_lt) begin
            w_used = r_mem_q;
        end else if (w_word_eq) begin
            w_used = r_mem_q | (32'hFFFF_FFFF << w_limit[4:0]);
        end else begin
            w_used = 32'hFFFF_FFFF;
        end
    end

    assign w_found      = ~&w_used;
    assign w_found_bit  = first_zero(w_used);
    assign w_grant_addr = r_base + (32'({r_word, w_found_bit}) << pfba_pkg::FRAME_SHIFT);

    assign w_offset       = i_page_address - r_base;
    assign w_unaligned    = |w_offset[pfba_pkg::FRAME_SHIFT-1:0];
    assign w_out_of_range = (i_page_address < r_base)
                            || (32'(w_offset[31:pfba_pkg::FRAME_SHIFT]) >= 32'(w_limit));
    assign w_clr_last     = 32'(r_word) == 32'(MAP_WORDS - 1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            pfba_pkg::S_CLEAR: begin
                if (w_clr_last) begin
                    n_state = pfba_pkg::S_IDLE;
                end
            end
            pfba_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_cmd == pfba_pkg::CMD_ALLOC) begin
                        n_state = pfba_pkg::S_ALLOC_CHK;
                    end else if (!w_unaligned && !w_out_of_range) begin
                        n_state = pfba_pkg::S_FREE_CHK;
                    end
                end
            end
            pfba_pkg::S_ALLOC_CHK: begin
                if (w_found || w_last_word) begin
                    n_state = pfba_pkg::S_IDLE;
                end
            end
            pfba_pkg::S_FREE_CHK: begin
                n_state = pfba_pkg::S_IDLE;
            end
            default: begin
                n_state = pfba_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_word;
        w_wr_en   = 1'b0;
        w_wr_addr = r_word;
        w_wr_data = 32'd0;
        n_word    = r_word;
        n_bit     = r_bit;
        n_valid   = 1'b0;
        n_grant   = 32'd0;
        n_status  = pfba_pkg::ST_OK;
        case (r_state)
            pfba_pkg::S_CLEAR: begin
                w_wr_en = 1'b1;
                n_word  = w_clr_last ? '0 : r_word + WRD_W'(1);
            end
            pfba_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_cmd == pfba_pkg::CMD_ALLOC) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = '0;
                        n_word    = '0;
                    end else if (w_unaligned) begin
                        n_valid  = 1'b1;
                        n_status = pfba_pkg::ST_UNALIGNED;
                    end else if (w_out_of_range) begin
                        n_valid  = 1'b1;
                        n_status = pfba_pkg::ST_OUT_OF_RANGE;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_offset[pfba_pkg::FRAME_SHIFT+5 +: WRD_W];
                        n_word    = w_offset[pfba_pkg::FRAME_SHIFT+5 +: WRD_W];
                        n_bit     = w_offset[pfba_pkg::FRAME_SHIFT +: 5];
                    end
                end
            end
            pfba_pkg::S_ALLOC_CHK: begin
                if (w_found) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = r_mem_q | (32'd1 << w_found_bit);
                    n_valid   = 1'b1;
                    n_grant   = w_grant_addr;
                end else if (w_last_word) begin
                    n_valid  = 1'b1;
                    n_status = pfba_pkg::ST_NO_FREE;
                end else begin
                    // advance the scan to the next word
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_word + WRD_W'(1);
                    n_word    = r_word + WRD_W'(1);
                end
            end
            pfba_pkg::S_FREE_CHK: begin
                n_valid = 1'b1;
                if (r_mem_q[r_bit]) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = r_mem_q & ~(32'd1 << r_bit);
                end else begin
                    n_status = pfba_pkg::ST_NOT_ALLOCATED;
                end
            end
            default: begin
                n_word = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_mem_q <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pfba_pkg::S_CLEAR;
            r_word       <= '0;
            r_valid      <= 1'b0;
            r_base       <= 32'd0;
            r_page_count <= 13'd0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pfba_pkg::REG_BASE_ADDRESS: r_base       <= i_cfg_wdata;
                    pfba_pkg::REG_PAGE_COUNT:   r_page_count <= i_cfg_wdata[12:0];
                    default: begin
                        // drop writes to unknown registers
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit    <= n_bit;
        r_grant  <= n_grant;
        r_status <= n_status;
    end

    assign o_busy            = r_state != pfba_pkg::S_IDLE;
    assign o_valid           = r_valid;
    assign o_granted_address = r_grant;
    assign o_status          = r_status;

endmodule

>>> bench/page_frame_bitmap_allocator_top_tb.sv
module page_frame_bitmap_allocator_top_tb;

    localparam int unsigned WORD_BITS   = pfba_pkg::WORD_BITS;
    localparam int unsigned FRAME_SHIFT = pfba_pkg::FRAME_SHIFT;

    localparam logic [2:0] ST_OK            = pfba_pkg::ST_OK;
    localparam logic [2:0] ST_NO_FREE       = pfba_pkg::ST_NO_FREE;
    localparam logic [2:0] ST_UNALIGNED     = pfba_pkg::ST_UNALIGNED;
    localparam logic [2:0] ST_NOT_ALLOCATED = pfba_pkg::ST_NOT_ALLOCATED;
    localparam logic [2:0] ST_OUT_OF_RANGE  = pfba_pkg::ST_OUT_OF_RANGE;

    localparam logic       CMD_ALLOC = pfba_pkg::CMD_ALLOC;
    localparam logic       CMD_FREE  = pfba_pkg::CMD_FREE;

    localparam logic [1:0] REG_BASE_ADDRESS = pfba_pkg::REG_BASE_ADDRESS;
    localparam logic [1:0] REG_PAGE_COUNT   = pfba_pkg::REG_PAGE_COUNT;

    localparam int unsigned NFRAMES      = pfba_pkg::MAX_PAGES_DEF;
    localparam int unsigned NWORDS       = NFRAMES / WORD_BITS;
    localparam int unsigned WIDX_W       = $clog2(NWORDS);
    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned DRAIN_CYCLES = 2 * NWORDS + 8;
    localparam int unsigned SHOW_MAX     = 10;

    // register indexes the block does not decode
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [31:0] addr;
        logic [2:0]  status;
    } t_answer;

    typedef enum logic {ROW_CMD, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  reg_idx;
        logic        cmd;
        logic [31:0] word;
        logic        checked;
        logic [31:0] want_addr;
        logic [2:0]  want_status;
    } t_plan_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_start        = 1'b0;
    logic        i_cmd          = CMD_ALLOC;
    logic [31:0] i_page_address = '0;
    logic        i_cfg_we       = 1'b0;
    logic [1:0]  i_cfg_idx      = REG_BASE_ADDRESS;
    logic [31:0] i_cfg_wdata    = '0;
    logic        o_busy;
    logic        o_valid;
    logic [31:0] o_granted_address;
    logic [2:0]  o_status;

    page_frame_bitmap_allocator_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_cmd             (i_cmd),
        .i_page_address    (i_page_address),
        .o_valid           (o_valid),
        .o_granted_address (o_granted_address),
        .o_status          (o_status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // shadow of the allocator: registers, usage bitmap, answers in flight
    logic [31:0]  cur_base  = '0;
    logic [12:0]  cur_count = '0;
    logic [31:0]  frame_map [NWORDS] = '{default: '0};
    t_answer      answers_due [$];
    int unsigned  held_frames [$];

    int unsigned  sender_idle_pct = 0;
    int unsigned  n_bad      = 0;
    int unsigned  n_cmds     = 0;
    int unsigned  n_grants   = 0;
    int unsigned  n_released = 0;
    int unsigned  n_refused  = 0;
    int unsigned  n_settings = 0;
    int unsigned  quiet      = 0;

    t_plan_row plan [28] = '{
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_ALLOC, 32'h0000_0000, 1'b1, 32'h0, ST_NO_FREE},
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_FREE,  32'h0000_0000, 1'b1, 32'h0, ST_OUT_OF_RANGE},
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_FREE,  32'hFFFF_FFFF, 1'b1, 32'h0, ST_UNALIGNED},
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_FREE,  32'h0000_0800, 1'b1, 32'h0, ST_UNALIGNED},
        '{ROW_CFG, REG_BASE_ADDRESS, CMD_ALLOC, 32'hFFFF_E000, 1'b0, 32'h0, ST_OK},
        '{ROW_CFG, REG_PAGE_COUNT,   CMD_ALLOC, 32'h0000_1FFF, 1'b0, 32'h0, ST_OK},
        '{ROW_CFG, REG_SPARE_A,      CMD_ALLOC, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
        '{ROW_CFG, REG_SPARE_B,      CMD_ALLOC, 32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK},
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_ALLOC, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_E000, ST_OK},
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_ALLOC, 32'h0000_0000, 1'b1, 32'hFFFF_F000, ST_OK},
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_ALLOC, 32'hA5A5_5A5A, 1'b1, 32'h0000_0000, ST_OK},
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_FREE,  32'hFFFF_F000, 1'b1, 32'h0, ST_OK},
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_FREE,  32'hFFFF_F000, 1'b1, 32'h0, ST_NOT_ALLOCATED},
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_FREE,  32'h0000_0000, 1'b1, 32'h0, ST_OUT_OF_RANGE},
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_FREE,  32'h1234_5000, 1'b1, 32'h0, ST_OUT_OF_RANGE},
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_ALLOC, 32'h0000_0000, 1'b1, 32'hFFFF_F000, ST_OK},
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_FREE,  32'hFFFF_E800, 1'b1, 32'h0, ST_UNALIGNED},
        '{ROW_CFG, REG_BASE_ADDRESS, CMD_ALLOC, 32'h0000_1800, 1'b0, 32'h0, ST_OK},
        '{ROW_CFG, REG_PAGE_COUNT,   CMD_ALLOC, 32'h0000_0002, 1'b0, 32'h0, ST_OK},
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_FREE,  32'h0000_1800, 1'b1, 32'h0, ST_OK},
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_FREE,  32'h0000_3800, 1'b1, 32'h0, ST_OUT_OF_RANGE},
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_FREE,  32'h0000_2000, 1'b1, 32'h0, ST_UNALIGNED},
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_ALLOC, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_ALLOC, 32'h0000_0000, 1'b1, 32'h0, ST_NO_FREE},
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_FREE,  32'h0000_0800, 1'b1, 32'h0, ST_OUT_OF_RANGE},
        '{ROW_CFG, REG_PAGE_COUNT,   CMD_ALLOC, 32'h0000_1000, 1'b0, 32'h0, ST_OK},
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_ALLOC, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
        '{ROW_CMD, REG_BASE_ADDRESS, CMD_FREE,  32'hFFFF_F800, 1'b1, 32'h0, ST_OUT_OF_RANGE}
    };

    function automatic int unsigned usable_frames();
        return (cur_count > NFRAMES) ? NFRAMES : int'(cur_count);
    endfunction

    // Answer one command and update the shadow bitmap the way the block should.
    function automatic t_answer frame_outcome(input logic cmd, input logic [31:0] addr);
        t_answer           res;
        int unsigned       lim;
        int unsigned       pg;
        logic [31:0]       offset;
        logic [WIDX_W-1:0] wi;
        logic [4:0]        bi;
        lim = usable_frames();
        res.addr   = '0;
        res.status = ST_NO_FREE;
        if (cmd == CMD_ALLOC) begin
            for (pg = 0; pg < lim; pg++) begin
                wi = WIDX_W'(pg / WORD_BITS);
                bi = 5'(pg % WORD_BITS);
                if (!frame_map[wi][bi]) begin
                    frame_map[wi][bi] = 1'b1;
                    res.addr   = cur_base + (pg << FRAME_SHIFT);
                    res.status = ST_OK;
                    return res;
                end
            end
            return res;
        end
        offset = addr - cur_base;
        if (offset[FRAME_SHIFT-1:0] != '0) begin
            res.status = ST_UNALIGNED;
        end else if (addr < cur_base || (offset >> FRAME_SHIFT) >= lim) begin
            res.status = ST_OUT_OF_RANGE;
        end else begin
            pg = offset >> FRAME_SHIFT;
            wi = WIDX_W'(pg / WORD_BITS);
            bi = 5'(pg % WORD_BITS);
            if (!frame_map[wi][bi]) begin
                res.status = ST_NOT_ALLOCATED;
            end else begin
                frame_map[wi][bi] = 1'b0;
                res.status = ST_OK;
            end
        end
        return res;
    endfunction

    // Hold the command channel until every answer is in and the block is free.
    task automatic wait_idle();
        i_start  <= 1'b0;
        i_cfg_we <= 1'b0;
        do @(posedge i_clk); while (answers_due.size() != 0 || o_busy);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        if (idx == REG_BASE_ADDRESS) begin
            cur_base = data;
        end else if (idx == REG_PAGE_COUNT) begin
            cur_count = data[12:0];
            n_settings++;
        end
    endtask

    task automatic push_cmd(input logic cmd, input logic [31:0] addr, input logic checked,
                            input logic [31:0] want_addr, input logic [2:0] want_status);
        t_answer     pred;
        t_answer     typed;
        int unsigned pg;
        int unsigned k;
        i_cfg_we <= 1'b0;
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            i_start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
        i_start        <= 1'b1;
        i_cmd          <= cmd;
        i_page_address <= addr;
        do @(posedge i_clk); while (o_busy);
        // transaction taken at this edge
        pred = frame_outcome(cmd, addr);
        typed.addr   = want_addr;
        typed.status = want_status;
        answers_due.push_back(checked ? typed : pred);
        n_cmds++;
        if (pred.status != ST_OK) begin
            n_refused++;
        end else if (cmd == CMD_ALLOC) begin
            n_grants++;
            held_frames.push_back((pred.addr - cur_base) >> FRAME_SHIFT);
        end else begin
            n_released++;
            pg = (addr - cur_base) >> FRAME_SHIFT;
            for (k = 0; k < held_frames.size(); k++) begin
                if (held_frames[k] == pg) begin
                    held_frames.delete(k);
                    break;
                end
            end
        end
    endtask

    // Mostly allocations and frees of held frames; the rest near misses and noise.
    task automatic push_random(input int unsigned alloc_pct);
        int unsigned roll;
        int unsigned lim;
        logic [31:0] addr;
        logic        cmd;
        roll = $urandom_range(0, 99);
        lim  = usable_frames();
        cmd  = CMD_FREE;
        if (roll < alloc_pct) begin
            cmd  = CMD_ALLOC;
            addr = $urandom;
        end else if (roll < alloc_pct + 30 && held_frames.size() != 0) begin
            addr = cur_base + (held_frames[$urandom_range(0, held_frames.size() - 1)]
                               << FRAME_SHIFT);
        end else if (roll < alloc_pct + 42) begin
            addr = cur_base + ($urandom_range(0, lim + 8) << FRAME_SHIFT);
        end else begin
            case ($urandom_range(0, 2))
                0: addr = $urandom;
                1: addr = cur_base - ($urandom_range(1, 16) << FRAME_SHIFT);
                default: addr = cur_base + ($urandom_range(0, lim) << FRAME_SHIFT)
                                 + $urandom_range(1, 4095);
            endcase
        end
        push_cmd(cmd, addr, 1'b0, '0, ST_OK);
    endtask

    // Results cannot be held off: take each one on the edge that ends its strobe.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid) begin
            if (answers_due.size() == 0) begin
                n_bad++;
                if (n_bad <= SHOW_MAX)
                    $display("tb: unexpected result addr=%h status=%0d",
                             o_granted_address, o_status);
            end else begin
                want = answers_due.pop_front();
                if (o_granted_address !== want.addr || o_status !== want.status) begin
                    n_bad++;
                    if (n_bad <= SHOW_MAX)
                        $display("tb: mismatch expected addr=%h status=%0d, got addr=%h status=%0d",
                                 want.addr, want.status, o_granted_address, o_status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || i_cfg_we)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("tb: no progress for %0d cycles", QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int unsigned r;
        int unsigned ph;
        int unsigned n;
        int unsigned n_items;
        int unsigned alloc_pct;
        logic [31:0] base_w;
        logic [31:0] count_w;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // wait out the bitmap sweep
        do @(posedge i_clk); while (o_busy);

        sender_idle_pct = 30;
        for (r = 0; r < $size(plan); r++) begin
            if (plan[r].kind == ROW_CFG) begin
                wait_idle();
                reg_write(plan[r].reg_idx, plan[r].word);
            end else begin
                push_cmd(plan[r].cmd, plan[r].word, plan[r].checked,
                         plan[r].want_addr, plan[r].want_status);
            end
        end

        for (ph = 0; ph < 10; ph++) begin
            base_w    = $urandom & 32'hFFFF_F000;
            alloc_pct = 45;
            case (ph)
                0: begin count_w = $urandom_range(1, 70); sender_idle_pct = 0; n_items = 150; end
                1: begin
                    base_w = 32'hFFFF_0000; count_w = 40; sender_idle_pct = 82; n_items = 150;
                end
                // lower the count over frames still held
                2: begin
                    base_w = 32'hFFFF_0000; count_w = 5; sender_idle_pct = 21; n_items = 120;
                end
                3: begin
                    base_w = $urandom; count_w = $urandom_range(1, 100);
                    sender_idle_pct = 0; n_items = 150;
                end
                // upper bits of the write data are dropped: count lands on 4096
                4: begin
                    base_w = 32'h0; count_w = 32'hFFFF_1000; sender_idle_pct = 82;
                    n_items = 150; alloc_pct = 60;
                end
                5: begin count_w = 0; sender_idle_pct = 21; n_items = 40; end
                6: begin count_w = 32'h0000_1FFF; sender_idle_pct = 0; n_items = 150; end
                7: begin count_w = 1; sender_idle_pct = 82; n_items = 100; end
                8: begin
                    count_w = $urandom_range(33, 300); sender_idle_pct = 21;
                    n_items = 170; alloc_pct = 55;
                end
                default: begin
                    count_w = NFRAMES; sender_idle_pct = 0; n_items = 100; alloc_pct = 60;
                end
            endcase
            wait_idle();
            reg_write(REG_BASE_ADDRESS, base_w);
            reg_write(REG_PAGE_COUNT, count_w);
            if ($urandom_range(0, 1))
                reg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
            for (n = 0; n < n_items; n++) begin
                // now and then drain completely before the next transaction
                if ($urandom_range(0, 99) == 0)
                    wait_idle();
                push_random(alloc_pct);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb: %0d commands over %0d page count settings: %0d grants, %0d frees, %0d refused",
                 n_cmds, n_settings, n_grants, n_released, n_refused);
        $display("tb: %0d mismatches, %0d answers outstanding", n_bad, answers_due.size());
        if (n_bad == 0 && answers_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> page_frame_bitmap_allocator_top.f
src/pfba_pkg.sv
src/page_frame_bitmap_allocator_top.sv
bench/page_frame_bitmap_allocator_top_tb.sv
